// ===== rtl/node_heartbeat_liveness_monitor_macros.svh =====
// assertion helpers for the rtl file of the liveness monitor
`ifndef NODE_HEARTBEAT_LIVENESS_MONITOR_MACROS_SVH
`define NODE_HEARTBEAT_LIVENESS_MONITOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NHLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("liveness monitor check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NHLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("liveness monitor check failed");

`endif

// ===== rtl/nhlm_pkg.sv =====
`default_nettype none

package nhlm_pkg;

  // slot table size
  localparam int NodeSlotsDefault = 7;

  // field widths
  localparam int IdW     = 29;
  localparam int LenW    = 4;
  localparam int PayW    = 24;
  localparam int ByteW   = 8;
  localparam int SlotW   = 3;
  localparam int MaskW   = 7;
  localparam int TimeW   = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStateIdBase   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeartbeatCode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgActiveCode    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgOfflineTmo    = 2'd3;

  // register reset values
  localparam logic [ByteW-1:0] ActiveCodeReset = 8'd1;
  localparam logic [TimeW-1:0] OfflineTmoReset = 32'd3000;

  // frame length limits
  localparam logic [LenW-1:0] MinFrameLen   = 4'd2;
  localparam logic [LenW-1:0] ResetReasonLen = 4'd3;

  // item modes
  localparam logic ModeFrame = 1'b0;
  localparam logic ModeTick  = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [IdW-1:0]  frame_id;
    logic [LenW-1:0] frame_length;
    logic [PayW-1:0] payload_low;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             changed;
    logic [SlotW-1:0] slot;
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] node_reason;
    logic [ByteW-1:0] node_reset_reason;
    logic [MaskW-1:0] newly_offline_mask;
    logic [MaskW-1:0] seen_mask;
    logic [MaskW-1:0] offline_mask;
    logic [MaskW-1:0] active_mask;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/node_heartbeat_liveness_monitor.sv =====
// Node liveness monitor. Each input item is either a received state frame or one time
// tick. A state frame whose identifier lies strictly between the configured base and
// base plus NODE_SLOTS, with a length of at least 2, updates that node's slot (state,
// reason, reset reason, last-seen time); a plain heartbeat from a known node keeps the
// stored reason bytes. A tick advances the time and marks offline every seen node that
// has been silent for at least the timeout. Every item returns exactly one result with
// the seen, offline and active masks after the update. The block takes one item per
// clock cycle while the output is not stalled; items pass through the input register
// and the result register, with all per-slot timeout compares done in parallel between
// them. The slot table is cleared by reset, so no item waits for a clearing pass. The
// user must write configuration only while no item is in flight; the block does not enforce it.
`default_nettype none

`include "node_heartbeat_liveness_monitor_macros.svh"

module node_heartbeat_liveness_monitor #(
  parameter int NodeSlots = nhlm_pkg::NodeSlotsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire nhlm_pkg::in_item_t            in_item_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output nhlm_pkg::out_item_t                out_item_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [nhlm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nhlm_pkg::CfgDatW-1:0]  cfg_data_i
);

  localparam int ByteW = nhlm_pkg::ByteW;
  localparam int TimeW = nhlm_pkg::TimeW;
  localparam int IdW   = nhlm_pkg::IdW;
  localparam int SlotW = nhlm_pkg::SlotW;
  localparam int MaskW = nhlm_pkg::MaskW;

  // configuration registers
  logic [IdW-1:0]   id_base_q;
  logic [ByteW-1:0] hb_code_q;
  logic [ByteW-1:0] act_code_q;
  logic [TimeW-1:0] tmo_q;

  // input register
  logic               s1_valid_q, s1_valid_d;
  nhlm_pkg::in_item_t s1_item_q;

  // result register
  logic                out_valid_q, out_valid_d;
  nhlm_pkg::out_item_t out_item_q, out_item_d;

  // slot table
  logic             seen_q   [NodeSlots];
  logic             seen_d   [NodeSlots];
  logic             off_q    [NodeSlots];
  logic             off_d    [NodeSlots];
  logic [ByteW-1:0] state_q  [NodeSlots];
  logic [ByteW-1:0] state_d  [NodeSlots];
  logic [ByteW-1:0] reason_q [NodeSlots];
  logic [ByteW-1:0] reason_d [NodeSlots];
  logic [ByteW-1:0] rstrsn_q [NodeSlots];
  logic [ByteW-1:0] rstrsn_d [NodeSlots];
  logic [TimeW-1:0] last_q   [NodeSlots];
  logic [TimeW-1:0] last_d   [NodeSlots];
  logic [TimeW-1:0] tick_q, tick_d;

  logic in_xfer;
  logic advance;
  logic work;

  // frame decode
  logic [IdW-1:0]   id_diff;
  logic             id_hit;
  logic             frame_ok;
  logic [SlotW-1:0] slot;
  logic [ByteW-1:0] fr_state;
  logic [ByteW-1:0] fr_reason;
  logic [ByteW-1:0] fr_rstrsn;
  logic             is_hb;
  logic [TimeW-1:0] tick_nx;

  // selected slot contents
  logic             sel_seen;
  logic             sel_off;
  logic [ByteW-1:0] sel_state;
  logic [ByteW-1:0] sel_reason;
  logic [ByteW-1:0] sel_rstrsn;

  logic             chg;
  logic [ByteW-1:0] st_reason;
  logic [ByteW-1:0] st_rstrsn;
  logic [MaskW-1:0] newly;
  logic [MaskW-1:0] seen_m;
  logic [MaskW-1:0] off_m;
  logic [MaskW-1:0] act_m;

  // handshakes
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign work        = s1_valid_q && advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // frame decode and selected slot read
  always_comb begin
    id_diff   = s1_item_q.frame_id - id_base_q;
    id_hit    = (s1_item_q.frame_id > id_base_q) && (id_diff < IdW'(NodeSlots));
    frame_ok  = (s1_item_q.mode == nhlm_pkg::ModeFrame) && id_hit &&
                (s1_item_q.frame_length >= nhlm_pkg::MinFrameLen);
    slot      = id_diff[SlotW-1:0];
    fr_state  = s1_item_q.payload_low[ByteW-1:0];
    fr_reason = s1_item_q.payload_low[2*ByteW-1:ByteW];
    fr_rstrsn = (s1_item_q.frame_length >= nhlm_pkg::ResetReasonLen) ?
                s1_item_q.payload_low[3*ByteW-1:2*ByteW] : '0;
    is_hb     = fr_reason == hb_code_q;
    tick_nx   = tick_q + TimeW'(1);

    sel_seen   = 1'b0;
    sel_off    = 1'b0;
    sel_state  = '0;
    sel_reason = '0;
    sel_rstrsn = '0;
    for (int n = 0; n < NodeSlots; n++) begin
      if (slot == SlotW'(n)) begin
        sel_seen   = seen_q[n];
        sel_off    = off_q[n];
        sel_state  = state_q[n];
        sel_reason = reason_q[n];
        sel_rstrsn = rstrsn_q[n];
      end
    end

    chg = !sel_seen || sel_off || (sel_state != fr_state) ||
          (!is_hb && ((sel_reason != fr_reason) || (sel_rstrsn != fr_rstrsn)));
    st_reason = (is_hb && sel_seen) ? sel_reason : fr_reason;
    st_rstrsn = (is_hb && sel_seen) ? sel_rstrsn : fr_rstrsn;
  end

  // table update
  always_comb begin
    tick_d = tick_q;
    newly  = '0;
    for (int n = 0; n < NodeSlots; n++) begin
      seen_d[n]   = seen_q[n];
      off_d[n]    = off_q[n];
      state_d[n]  = state_q[n];
      reason_d[n] = reason_q[n];
      rstrsn_d[n] = rstrsn_q[n];
      last_d[n]   = last_q[n];
    end
    if (work) begin
      if (s1_item_q.mode == nhlm_pkg::ModeTick) begin
        tick_d = tick_nx;
        for (int n = 1; n < NodeSlots; n++) begin
          if (seen_q[n] && !off_q[n] && ((tick_nx - last_q[n]) >= tmo_q)) begin
            off_d[n] = 1'b1;
            newly[n] = 1'b1;
          end
        end
      end else if (frame_ok) begin
        for (int n = 0; n < NodeSlots; n++) begin
          if (slot == SlotW'(n)) begin
            seen_d[n]   = 1'b1;
            off_d[n]    = 1'b0;
            state_d[n]  = fr_state;
            reason_d[n] = st_reason;
            rstrsn_d[n] = st_rstrsn;
            last_d[n]   = tick_q;
          end
        end
      end
    end
  end

  // masks after the update
  always_comb begin
    seen_m = '0;
    off_m  = '0;
    act_m  = '0;
    for (int n = 0; n < NodeSlots; n++) begin
      seen_m[n] = seen_d[n];
      off_m[n]  = seen_d[n] && off_d[n];
      act_m[n]  = seen_d[n] && !off_d[n] && (state_d[n] == act_code_q);
    end
  end

  // result build
  always_comb begin
    out_item_d = out_item_q;
    if (work) begin
      out_item_d.accepted           = frame_ok;
      out_item_d.changed            = frame_ok && chg;
      out_item_d.slot               = frame_ok ? slot : '0;
      out_item_d.status_byte        = frame_ok ? fr_state : '0;
      out_item_d.node_reason        = frame_ok ? st_reason : '0;
      out_item_d.node_reset_reason  = frame_ok ? st_rstrsn : '0;
      out_item_d.newly_offline_mask = newly;
      out_item_d.seen_mask          = seen_m;
      out_item_d.offline_mask       = off_m;
      out_item_d.active_mask        = act_m;
    end
  end

  // valid flags
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // control, table and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      id_base_q   <= '0;
      hb_code_q   <= '0;
      act_code_q  <= nhlm_pkg::ActiveCodeReset;
      tmo_q       <= nhlm_pkg::OfflineTmoReset;
      for (int n = 0; n < NodeSlots; n++) begin
        seen_q[n]   <= 1'b0;
        off_q[n]    <= 1'b0;
        state_q[n]  <= '0;
        reason_q[n] <= '0;
        rstrsn_q[n] <= '0;
        last_q[n]   <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      tick_q      <= tick_d;
      for (int n = 0; n < NodeSlots; n++) begin
        seen_q[n]   <= seen_d[n];
        off_q[n]    <= off_d[n];
        state_q[n]  <= state_d[n];
        reason_q[n] <= reason_d[n];
        rstrsn_q[n] <= rstrsn_d[n];
        last_q[n]   <= last_d[n];
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nhlm_pkg::CfgStateIdBase:   id_base_q  <= cfg_data_i[IdW-1:0];
          nhlm_pkg::CfgHeartbeatCode: hb_code_q  <= cfg_data_i[ByteW-1:0];
          nhlm_pkg::CfgActiveCode:    act_code_q <= cfg_data_i[ByteW-1:0];
          nhlm_pkg::CfgOfflineTmo:    tmo_q      <= cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  // checks
  `NHLM_ASSERT_IMP(a_slot_zero_unused, 1'b1, !seen_q[0])
  `NHLM_ASSERT_IMP(a_changed_needs_accept, out_valid_o && out_item_o.changed,
                   out_item_o.accepted && (out_item_o.slot != '0))
  `NHLM_ASSERT_IMP(a_offline_subset_seen, out_valid_o,
                   ((out_item_o.offline_mask & ~out_item_o.seen_mask) == '0) &&
                   ((out_item_o.offline_mask & out_item_o.active_mask) == '0))
  `NHLM_ASSERT_IMP(a_newly_in_offline, out_valid_o,
                   ((out_item_o.newly_offline_mask & ~out_item_o.offline_mask) == '0))
  `NHLM_ASSERT_NXT(a_result_follows_work, work, out_valid_o)

endmodule

`default_nettype wire
